@@ sv/dpt_pkg.sv @@
// dpt_pkg: shared constants, codes and types for the demand paging translator
// used by every module under sv/ except dpt_ram; depends on nothing
`default_nettype none

package dpt_pkg;

	// address and page fields
	localparam int ADDR_W       = 16;
	localparam int PAGE_W       = ADDR_W;
	localparam int DIV_W        = ADDR_W + 1;
	localparam int STEP_W       = $clog2(ADDR_W);

	// page map and frames
	localparam int PAGE_ENTRIES = 64;
	localparam int PAGE_IDX_W   = $clog2(PAGE_ENTRIES);
	localparam int FRAME_COUNT  = 4;
	localparam int FRAME_W      = 2;

	// counters
	localparam int CNT_W        = 32;

	// queue between front and back
	localparam int QUEUE_DEPTH  = 2;

	// configuration port
	localparam int PDATA_W      = 32;
	localparam int PADDR_W      = 3;
	localparam int REG_IDX_LSB  = 2;
	localparam logic [PADDR_W-REG_IDX_LSB-1:0] REG_PG_BYTES = '0;
	localparam logic [PAGE_W-1:0] PG_BYTES_RST = 16'd256;

	typedef enum logic [1:0] {
		ST_HIT    = 2'd0,
		ST_LOADED = 2'd1,
		ST_FULL   = 2'd2,
		ST_RANGE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic {
		B_IDLE,
		B_RESOLVE
	} back_state_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [PAGE_W-1:0] offset;
	} q_item_t;

	// handshake from a producer into a queue
	typedef struct packed {
		logic push;
	} q_wr_ctl_t;

endpackage

`default_nettype wire

@@ sv/dpt_ram.sv @@
// dpt_ram: generic single write port, single read port ram with registered read
// self-contained, no package needed
`default_nettype none

module dpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ sv/dpt_front.sv @@
// dpt_front: accepts addresses and splits them into page and offset
// with a radix-2 restoring divider; uses dpt_pkg
`default_nettype none

module dpt_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	output logic                            full,
	input  wire logic [dpt_pkg::ADDR_W-1:0] address,
	input  wire logic [dpt_pkg::PAGE_W-1:0] pg_bytes,
	output dpt_pkg::q_item_t                item,
	output dpt_pkg::q_wr_ctl_t              item_ctl,
	input  wire logic                       item_full
);

	localparam logic [dpt_pkg::STEP_W-1:0] STEP_LAST = dpt_pkg::STEP_W'(dpt_pkg::ADDR_W - 1);

	dpt_pkg::front_state_t state_q, state_d;

	logic [dpt_pkg::ADDR_W-1:0] dq_q;
	logic [dpt_pkg::ADDR_W-1:0] rem_q;
	logic [dpt_pkg::DIV_W-1:0]  div_q;
	logic [dpt_pkg::STEP_W-1:0] step_q;

	logic                       accept;
	logic [dpt_pkg::DIV_W-1:0]  trial;
	logic [dpt_pkg::DIV_W-1:0]  diff;
	logic                       ge;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dpt_pkg::F_IDLE: begin
				if (push) begin
					state_d = dpt_pkg::F_DIV;
				end
			end
			dpt_pkg::F_DIV: begin
				if (step_q == STEP_LAST) begin
					state_d = dpt_pkg::F_PUSH;
				end
			end
			dpt_pkg::F_PUSH: begin
				if (!item_full) begin
					state_d = dpt_pkg::F_IDLE;
				end
			end
			default: state_d = dpt_pkg::F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		full          = 1'b1;
		accept        = 1'b0;
		item_ctl.push = 1'b0;
		case (state_q)
			dpt_pkg::F_IDLE: begin
				full   = 1'b0;
				accept = push;
			end
			dpt_pkg::F_PUSH: begin
				item_ctl.push = !item_full;
			end
			default: begin
				full = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpt_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// one quotient bit per cycle
	assign trial = {rem_q, dq_q[dpt_pkg::ADDR_W-1]};
	assign ge    = (trial >= div_q);
	assign diff  = trial - div_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			dq_q   <= address;
			rem_q  <= '0;
			div_q  <= (pg_bytes == '0) ? {1'b1, {dpt_pkg::PAGE_W{1'b0}}} : {1'b0, pg_bytes};
			step_q <= '0;
		end else if (state_q == dpt_pkg::F_DIV) begin
			dq_q   <= {dq_q[dpt_pkg::ADDR_W-2:0], ge};
			rem_q  <= ge ? diff[dpt_pkg::ADDR_W-1:0] : trial[dpt_pkg::ADDR_W-1:0];
			step_q <= step_q + 1'b1;
		end
	end

	assign item.page   = dq_q;
	assign item.offset = rem_q;

endmodule

`default_nettype wire

@@ sv/dpt_queue.sv @@
// dpt_queue: short fifo of page/offset items between front and back
// uses dpt_pkg
`default_nettype none

module dpt_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  dpt_pkg::q_wr_ctl_t    wr_ctl,
	input  dpt_pkg::q_item_t      item_in,
	output logic                  full,
	input  wire logic             pop,
	output dpt_pkg::q_item_t      item_out,
	output logic                  empty
);

	localparam int PTR_W = (dpt_pkg::QUEUE_DEPTH > 1) ? $clog2(dpt_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(dpt_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(dpt_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(dpt_pkg::QUEUE_DEPTH);

	dpt_pkg::q_item_t  slot_q [dpt_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == CNT_FULL);
	assign empty    = (count_q == '0);
	assign do_push  = wr_ctl.push && !full;
	assign do_pop   = pop && !empty;
	assign item_out = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/dpt_back.sv @@
// dpt_back: page map lookup, free frame claim, counters and result register
// uses dpt_pkg and dpt_ram
`default_nettype none

module dpt_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      q_empty,
	input  dpt_pkg::q_item_t               q_item,
	output logic                           q_pop,
	output logic                           empty,
	input  wire logic                      pop,
	output logic [dpt_pkg::PAGE_W-1:0]     page_number,
	output logic [dpt_pkg::PAGE_W-1:0]     page_offset,
	output logic [dpt_pkg::FRAME_W-1:0]    frame_number,
	output logic [1:0]                     status,
	output logic [dpt_pkg::CNT_W-1:0]      hit_count,
	output logic [dpt_pkg::CNT_W-1:0]      fault_count
);

	dpt_pkg::back_state_t state_q, state_d;

	dpt_pkg::q_item_t                  cur_q;
	logic [dpt_pkg::PAGE_ENTRIES-1:0]  map_valid_q;
	logic [dpt_pkg::FRAME_COUNT-1:0]   owner_valid_q;
	logic [dpt_pkg::CNT_W-1:0]         hits_q;
	logic [dpt_pkg::CNT_W-1:0]         faults_q;
	logic                              res_valid_q;
	logic [dpt_pkg::PAGE_W-1:0]        res_page_q;
	logic [dpt_pkg::PAGE_W-1:0]        res_offset_q;
	logic [dpt_pkg::FRAME_W-1:0]       res_frame_q;
	dpt_pkg::status_t                  res_status_q;

	logic                              start;
	logic                              resolve;
	logic [dpt_pkg::PAGE_IDX_W-1:0]    idx;
	logic                              in_range;
	logic                              hit;
	logic [dpt_pkg::FRAME_W-1:0]       map_frame;
	logic                              free_found;
	logic [dpt_pkg::FRAME_W-1:0]       free_idx;
	logic                              load;
	dpt_pkg::status_t                  status_d;
	logic [dpt_pkg::FRAME_W-1:0]       frame_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dpt_pkg::B_IDLE: begin
				if (!q_empty && (!res_valid_q || pop)) begin
					state_d = dpt_pkg::B_RESOLVE;
				end
			end
			dpt_pkg::B_RESOLVE: state_d = dpt_pkg::B_IDLE;
			default:            state_d = dpt_pkg::B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		start   = 1'b0;
		resolve = 1'b0;
		case (state_q)
			dpt_pkg::B_IDLE:    start   = !q_empty && (!res_valid_q || pop);
			dpt_pkg::B_RESOLVE: resolve = 1'b1;
			default:            start   = 1'b0;
		endcase
	end

	assign q_pop = start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpt_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cur_q <= q_item;
		end
	end

	dpt_ram #(
		.WIDTH(dpt_pkg::FRAME_W),
		.DEPTH(dpt_pkg::PAGE_ENTRIES)
	) u_map (
		.clk  (clk),
		.we   (load),
		.waddr(idx),
		.wdata(free_idx),
		.raddr(q_item.page[dpt_pkg::PAGE_IDX_W-1:0]),
		.rdata(map_frame)
	);

	assign idx      = cur_q.page[dpt_pkg::PAGE_IDX_W-1:0];
	assign in_range = ~|cur_q.page[dpt_pkg::PAGE_W-1:dpt_pkg::PAGE_IDX_W];
	assign hit      = map_valid_q[idx];

	// lowest empty frame
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int f = dpt_pkg::FRAME_COUNT - 1; f >= 0; f--) begin
			if (!owner_valid_q[f]) begin
				free_found = 1'b1;
				free_idx   = dpt_pkg::FRAME_W'(f);
			end
		end
	end

	always_comb begin
		load     = 1'b0;
		frame_d  = '0;
		status_d = dpt_pkg::ST_RANGE;
		if (in_range) begin
			if (hit) begin
				status_d = dpt_pkg::ST_HIT;
				frame_d  = map_frame;
			end else if (free_found) begin
				status_d = dpt_pkg::ST_LOADED;
				frame_d  = free_idx;
				load     = resolve;
			end else begin
				status_d = dpt_pkg::ST_FULL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_valid_q   <= '0;
			owner_valid_q <= '0;
			hits_q        <= '0;
			faults_q      <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (load) begin
				map_valid_q[idx]        <= 1'b1;
				owner_valid_q[free_idx] <= 1'b1;
			end
			if (resolve && in_range) begin
				if (hit) begin
					if (~&hits_q) begin
						hits_q <= hits_q + 1'b1;
					end
				end else if (~&faults_q) begin
					faults_q <= faults_q + 1'b1;
				end
			end
			if (resolve) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (resolve) begin
			res_page_q   <= cur_q.page;
			res_offset_q <= cur_q.offset;
			res_frame_q  <= frame_d;
			res_status_q <= status_d;
		end
	end

	// counters only move when a new result is loaded, so they are shown directly
	assign empty        = !res_valid_q;
	assign page_number  = res_page_q;
	assign page_offset  = res_offset_q;
	assign frame_number = res_frame_q;
	assign status       = res_status_q;
	assign hit_count    = hits_q;
	assign fault_count  = faults_q;

endmodule

`default_nettype wire

@@ sv/demand_paging_translate.sv @@
// demand_paging_translate: top level of the demand paging translator
// uses dpt_pkg, dpt_front, dpt_queue, dpt_back (dpt_ram below dpt_back)
//
// channel  | direction | transfer when          | payload
// ---------+-----------+------------------------+---------------------------------------
// input    | in        | push && !full          | address
// result   | out       | pop && !empty          | page_number, page_offset, frame_number,
//          |           |                        | status, hit_count, fault_count
// config   | in (apb)  | psel&penable&pwrite    | page size register at byte address 0
//
// an address passes these steps from transfer to result: the transfer edge loads the
// divider, the radix-2 restoring divider runs (one quotient bit a cycle), the item
// enters the queue, then the back part does a page map read and a resolve step.
// the front takes no new address until the last one has entered the queue.
// reset is asynchronous, active low; page map valid bits, frame ownership and
// counters clear at once, no clearing pass.
// a result that is not taken holds the back part; the queue keeps the front
// running until it fills, after which full stays high.
`default_nettype none

module demand_paging_translate (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input queue side
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic [dpt_pkg::ADDR_W-1:0]          address,
	// result queue side
	output logic                                     empty,
	input  wire logic                                pop,
	output logic [dpt_pkg::PAGE_W-1:0]               page_number,
	output logic [dpt_pkg::PAGE_W-1:0]               page_offset,
	output logic [dpt_pkg::FRAME_W-1:0]              frame_number,
	output logic [1:0]                               status,
	output logic [dpt_pkg::CNT_W-1:0]                hit_count,
	output logic [dpt_pkg::CNT_W-1:0]                fault_count,
	// configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [dpt_pkg::PADDR_W-1:0]         paddr,
	input  wire logic [dpt_pkg::PDATA_W-1:0]         pwdata,
	output logic [dpt_pkg::PDATA_W-1:0]              prdata,
	output logic                                     pready
);

	logic [dpt_pkg::PAGE_W-1:0] pg_bytes_q;
	logic                       reg_hit;
	logic                       cfg_wr;

	dpt_pkg::q_item_t           front_item;
	dpt_pkg::q_item_t           back_item;
	dpt_pkg::q_wr_ctl_t         front_ctl;
	logic                       q_full;
	logic                       q_empty;
	logic                       q_pop;

	// register file: one register, page size, byte lanes ignored
	assign pready  = 1'b1;
	assign reg_hit = (paddr[dpt_pkg::PADDR_W-1:dpt_pkg::REG_IDX_LSB]
		== dpt_pkg::REG_PG_BYTES);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? dpt_pkg::PDATA_W'(pg_bytes_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pg_bytes_q <= dpt_pkg::PG_BYTES_RST;
		end else if (cfg_wr) begin
			pg_bytes_q <= pwdata[dpt_pkg::PAGE_W-1:0];
		end
	end

	// front: accept and divide
	dpt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.address  (address),
		.pg_bytes (pg_bytes_q),
		.item     (front_item),
		.item_ctl (front_ctl),
		.item_full(q_full)
	);

	// decoupling queue
	dpt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_ctl  (front_ctl),
		.item_in (front_item),
		.full    (q_full),
		.pop     (q_pop),
		.item_out(back_item),
		.empty   (q_empty)
	);

	// back: lookup, allocate, count, hold result
	dpt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_item      (back_item),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.page_number (page_number),
		.page_offset (page_offset),
		.frame_number(frame_number),
		.status      (status),
		.hit_count   (hit_count),
		.fault_count (fault_count)
	);

endmodule

`default_nettype wire

@@ sv/dpt_checker.sv @@
// dpt_port_assert: port-level assertions for demand_paging_translate, bound to the top
// uses dpt_pkg
`default_nettype none

module dpt_port_assert (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        empty,
	input  wire logic                        pop,
	input  wire logic [dpt_pkg::PAGE_W-1:0]  page_number,
	input  wire logic [dpt_pkg::PAGE_W-1:0]  page_offset,
	input  wire logic [dpt_pkg::FRAME_W-1:0] frame_number,
	input  wire logic [1:0]                  status,
	input  wire logic [dpt_pkg::CNT_W-1:0]   hit_count,
	input  wire logic [dpt_pkg::CNT_W-1:0]   fault_count
);

	localparam logic [dpt_pkg::PAGE_W-1:0] PAGE_LIMIT = dpt_pkg::PAGE_W'(dpt_pkg::PAGE_ENTRIES);

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(page_number) && $stable(page_offset)
			&& $stable(frame_number) && $stable(status)))
		else $error("waiting result changed");

	// range status agrees with the page number
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((status == dpt_pkg::ST_RANGE) == (page_number >= PAGE_LIMIT)))
		else $error("range status mismatch");

	// no frame on memory full or out of range
	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status == dpt_pkg::ST_FULL || status == dpt_pkg::ST_RANGE))
			|-> (frame_number == '0))
		else $error("frame reported without a load");

	// a hit is already counted
	a_hit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == dpt_pkg::ST_HIT) |-> (hit_count != '0))
		else $error("hit with zero hit count");

	// a fault is already counted
	a_fault_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status == dpt_pkg::ST_LOADED || status == dpt_pkg::ST_FULL))
			|-> (fault_count != '0))
		else $error("fault with zero fault count");

endmodule

bind demand_paging_translate dpt_port_assert u_dpt_port_assert (.*);

`default_nettype wire
